FILE: design/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the clock page replacement pager
// sizes, flag bits, result kinds, request codes and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int FRAMES      = 32;
  localparam int PROCS       = 4;
  localparam int ARENA_PAGES = 16;
  localparam int BLOCKS      = 64;
  localparam int NPAGES      = PROCS * ARENA_PAGES;

  localparam int PRW = 2;                         // process field
  localparam int VW  = 4;                         // page field
  localparam int IW  = 6;                         // page table index
  localparam int FW  = 6;                         // frame field, holds unmapped
  localparam int FQW = 5;                         // free frame queue entry
  localparam int BW  = 6;                         // disk block
  localparam int TW  = $clog2(ARENA_PAGES + 1);   // pages per process
  localparam int FCW = $clog2(FRAMES + 1);
  localparam int BCW = $clog2(BLOCKS + 1);
  localparam int CDW = 7;                         // config data

  // flag bits of a page entry
  localparam logic [5:0] M_RES     = 6'b000001;
  localparam logic [5:0] M_DIRTY   = 6'b000010;
  localparam logic [5:0] M_REF     = 6'b000100;
  localparam logic [5:0] M_WRITTEN = 6'b001000;
  localparam logic [5:0] M_RE      = 6'b010000;
  localparam logic [5:0] M_WE      = 6'b100000;

  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_FAULT   = 2'd0,
    OP_EXTEND  = 2'd1,
    OP_DESTROY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_UPDATE = 3'd0,
    K_DWRITE = 3'd1,
    K_DREAD  = 3'd2,
    K_ZERO   = 3'd3,
    K_REPLY  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLT_PG,
    ST_SW_RING,
    ST_SW_PAGE,
    ST_SW_EVAL,
    ST_VICT,
    ST_LOAD,
    ST_LOAD_WR,
    ST_EXT,
    ST_DS_RING,
    ST_DS_EVAL,
    ST_DS_FREE,
    ST_DB_RD,
    ST_DB_PUSH,
    ST_DS_DONE
  } state_t;

  typedef struct packed {
    logic [BW-1:0] block;
    logic [FW-1:0] frame;
    logic [5:0]    flags;
  } page_ent_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic refill;
  } fifo_cmd_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } pg_cmd_t;

  typedef struct packed {
    kind_t          kind;
    logic           status;
    logic [PRW-1:0] owner;
    logic [VW-1:0]  page;
    logic [FW-1:0]  frame;
    logic [BW-1:0]  block;
    logic           read_ok;
    logic           write_ok;
    logic           last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/cpr_fifo.sv
// ----------------------------------------------------------------------------
// cpr_fifo: circular queue in a synchronous memory
// head entry read into an output register each cycle; entries not written
// since the last refill read as their own position
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_fifo import cpr_pkg::*; #(
  parameter int DEPTH       = 32,
  parameter int WIDTH       = 5,
  parameter int RESET_COUNT = 32,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  fifo_cmd_t        cmd,
  input  logic [WIDTH-1:0] push_data,
  input  logic [CW-1:0]    refill_count,
  output logic [WIDTH-1:0] rd_data,
  output logic [CW-1:0]    count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [AW-1:0]    head;
  logic [AW-1:0]    wa;
  logic [WIDTH-1:0] rd_q;
  logic             rd_inv;
  logic [AW-1:0]    rd_pos;
  logic             do_push;

  assign wa      = head + count[AW-1:0];
  // a push onto a full queue is dropped unless an entry leaves at once
  assign do_push = cmd.push && ((count < CW'(DEPTH)) || cmd.pop) && !cmd.refill;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= CW'(RESET_COUNT);
      vld   <= '0;
    end else if (cmd.refill) begin
      head  <= '0;
      count <= refill_count;
      vld   <= '0;
    end else begin
      if (cmd.pop) begin
        head <= head + AW'(1);
      end
      if (do_push) begin
        vld[wa] <= 1'b1;
      end
      if (cmd.pop && !do_push) begin
        count <= count - CW'(1);
      end else if (do_push && !cmd.pop) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wa] <= push_data;
    end
    rd_q   <= mem[head];
    rd_inv <= !vld[head];
    rd_pos <= head;
  end

  assign rd_data = rd_inv ? WIDTH'(rd_pos) : rd_q;

endmodule

`default_nettype wire

FILE: design/cpr_page_mem.sv
// ----------------------------------------------------------------------------
// cpr_page_mem: page table memory
// block, frame and flags per page; an entry that is not valid reads as
// unmapped with all flags clear
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_page_mem import cpr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  pg_cmd_t        cmd,
  input  logic [IW-1:0]  rd_addr,
  input  logic [IW-1:0]  wr_addr,
  input  page_ent_t      wr_data,
  input  logic [PRW-1:0] clr_proc,
  output page_ent_t      rd_data
);

  page_ent_t         mem [NPAGES];
  logic [NPAGES-1:0] vld;
  page_ent_t         rd_q;
  logic              rd_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clr) begin
      // drop every page of one process at once
      for (int i = 0; i < ARENA_PAGES; i++) begin
        vld[{clr_proc, VW'(i)}] <= 1'b0;
      end
    end else if (cmd.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_inv <= !vld[rd_addr];
  end

  always_comb begin
    rd_data = rd_q;
    if (rd_inv) begin
      rd_data.frame = FW'(FRAMES);
      rd_data.flags = '0;
    end
  end

endmodule

`default_nettype wire

FILE: design/clock_page_replacement_pager_unit.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_pager_unit: clock (second chance) pager
// page table, free frame queue, free block queue and clock ring held in
// synchronous memories, worked by one read-modify-write controller
// ----------------------------------------------------------------------------
// sequence: a rejected item gets its result straight from idle; extend and a
//   fault on a resident page finish in their first state, a fault taking a
//   free frame goes on through ST_LOAD and ST_LOAD_WR; a sweep passes each ring
//   entry visited through ST_SW_RING, ST_SW_PAGE and ST_SW_EVAL (and ST_VICT for
//   a dirty victim); destroy walks the ring entries (ST_DS_FREE when a frame is
//   freed), then the pages of the process, and ends in ST_DS_DONE
// throughput: one item at a time; a new request is taken only while idle
// reset: queues come up full (frames 0..31, blocks 0..63), ring empty, every
//   page unmapped; done by valid bits, no clearing pass
// results are strobed for one cycle and cannot be stalled by the receiver
`default_nettype none

module clock_page_replacement_pager_unit import cpr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  // request
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     op,
  input  logic [PRW-1:0] proc,
  input  logic [VW-1:0]  vpage,
  input  logic           write,
  // result beats
  output logic           strobe,
  output logic [2:0]     kind,
  output logic           status,
  output logic [PRW-1:0] owner,
  output logic [VW-1:0]  page,
  output logic [FW-1:0]  frame,
  output logic [BW-1:0]  block,
  output logic           read_ok,
  output logic           write_ok,
  output logic           last,
  // configuration
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [CDW-1:0] cfg_data
);

  state_t state, state_next;

  // latched request
  logic [PRW-1:0] proc_q;
  logic [VW-1:0]  vpage_q;
  logic           wr_q;
  page_ent_t      ent_q;      // entry of the faulting page
  logic [FW-1:0]  frame_q;    // frame given to the faulting page
  logic [IW-1:0]  e_q;        // ring entry under the clock hand
  logic [BW-1:0]  vblk_q;     // block of the victim
  logic [FCW-1:0] walk;
  logic [FCW-1:0] walk_n;
  logic [TW-1:0]  bi;
  logic [TW-1:0]  totals [PROCS];

  // memories
  fifo_cmd_t      ff_cmd, fb_cmd, rg_cmd;
  logic [FQW-1:0] ff_push, ff_rd;
  logic [BW-1:0]  fb_push, fb_rd;
  logic [IW-1:0]  rg_push, rg_rd;
  logic [FCW-1:0] ff_count, rg_count, ff_fill;
  logic [BCW-1:0] fb_count, fb_fill;
  pg_cmd_t        pg_cmd;
  logic [IW-1:0]  pg_rd_addr, pg_wr_addr;
  page_ent_t      pg_wr_data, pg_rd;

  // output register
  result_t res, emit_val;
  logic    emit;

  logic          cfg_wr;
  logic [IW-1:0] idx;
  logic [5:0]    nf;
  logic          proc_bad;

  assign busy      = (state != ST_IDLE);
  // a register write never shares its edge with an accepted request
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign idx       = {proc_q, vpage_q};
  assign proc_bad  = ({1'b0, proc} >= (PRW + 1)'(PROCS));

  // register writes refill a queue, clipped to its size (the frame count takes only the low six data bits)
  assign ff_fill = (cfg_data[5:0] > 6'(FRAMES)) ? FCW'(FRAMES) : FCW'(cfg_data[5:0]);
  assign fb_fill = (cfg_data > CDW'(BLOCKS)) ? BCW'(BLOCKS) : BCW'(cfg_data);

  cpr_fifo #(.DEPTH(FRAMES), .WIDTH(FQW), .RESET_COUNT(FRAMES)) u_free_frames (
    .clk, .rst, .cmd(ff_cmd), .push_data(ff_push), .refill_count(ff_fill),
    .rd_data(ff_rd), .count(ff_count)
  );

  cpr_fifo #(.DEPTH(BLOCKS), .WIDTH(BW), .RESET_COUNT(BLOCKS)) u_free_blocks (
    .clk, .rst, .cmd(fb_cmd), .push_data(fb_push), .refill_count(fb_fill),
    .rd_data(fb_rd), .count(fb_count)
  );

  cpr_fifo #(.DEPTH(FRAMES), .WIDTH(IW), .RESET_COUNT(0)) u_ring (
    .clk, .rst, .cmd(rg_cmd), .push_data(rg_push), .refill_count('0),
    .rd_data(rg_rd), .count(rg_count)
  );

  cpr_page_mem u_pages (
    .clk, .rst, .cmd(pg_cmd), .rd_addr(pg_rd_addr), .wr_addr(pg_wr_addr),
    .wr_data(pg_wr_data), .clr_proc(proc_q), .rd_data(pg_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_val    = '{kind: K_REPLY, status: 1'b0, owner: proc_q, page: '0,
                    frame: FW'(FRAMES), block: '0, read_ok: 1'b0,
                    write_ok: 1'b0, last: 1'b0};
    ff_cmd      = '0;
    fb_cmd      = '0;
    rg_cmd      = '0;
    ff_push     = pg_rd.frame[FQW-1:0];
    fb_push     = pg_rd.block;
    rg_push     = idx;
    pg_cmd      = '0;
    pg_rd_addr  = idx;
    pg_wr_addr  = idx;
    pg_wr_data  = pg_rd;
    nf          = pg_rd.flags;

    ff_cmd.refill = cfg_wr && (cfg_index == REG_FRAME_COUNT);
    fb_cmd.refill = cfg_wr && (cfg_index == REG_BLOCK_COUNT);

    unique case (state)
      ST_IDLE: begin
        pg_rd_addr = {proc, vpage};
        if (start) begin
          emit_val.owner  = proc;
          emit_val.status = 1'b1;
          emit_val.last   = 1'b1;
          unique case (op)
            OP_FAULT: begin
              emit_val.page = vpage;
              if (proc_bad || ({1'b0, vpage} >= totals[proc])) begin
                emit = 1'b1;
              end else begin
                state_next = ST_FLT_PG;
              end
            end
            OP_EXTEND: begin
              if (proc_bad || (fb_count == '0) || (totals[proc] >= TW'(ARENA_PAGES))) begin
                emit = 1'b1;
              end else begin
                state_next = ST_EXT;
              end
            end
            OP_DESTROY: begin
              if (proc_bad) begin
                emit = 1'b1;
              end else begin
                state_next = ST_DS_RING;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_FLT_PG: begin
        if ((pg_rd.flags & M_RES) != '0) begin
          // resident: permissions only
          nf = pg_rd.flags | M_RE | M_REF;
          if (wr_q) begin
            nf = nf | M_WE | M_DIRTY | M_WRITTEN;
          end else if ((pg_rd.flags & M_DIRTY) != '0) begin
            nf = nf | M_WE;
          end
          pg_cmd.wr        = 1'b1;
          pg_wr_data.flags = nf;
          emit             = 1'b1;
          emit_val         = '{kind: K_UPDATE, status: 1'b0, owner: proc_q,
                               page: vpage_q, frame: pg_rd.frame, block: pg_rd.block,
                               read_ok: |(nf & M_RE), write_ok: |(nf & M_WE),
                               last: 1'b1};
          state_next       = ST_IDLE;
        end else if ((ff_count != '0) && (rg_count < FCW'(FRAMES))) begin
          ff_cmd.pop = 1'b1;
          state_next = ST_LOAD;
        end else if (rg_count == '0) begin
          emit_val.status = 1'b1;
          emit_val.page   = vpage_q;
          emit_val.last   = 1'b1;
          emit            = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_SW_RING;
        end
      end

      // wait for the ring head to settle after a pop
      ST_SW_RING: state_next = ST_SW_PAGE;

      ST_SW_PAGE: begin
        pg_rd_addr = rg_rd;
        state_next = ST_SW_EVAL;
      end

      ST_SW_EVAL: begin
        rg_cmd.pop = 1'b1;
        pg_cmd.wr  = 1'b1;
        pg_wr_addr = e_q;
        emit       = 1'b1;
        emit_val   = '{kind: K_UPDATE, status: 1'b0, owner: e_q[IW-1:VW],
                       page: e_q[VW-1:0], frame: pg_rd.frame, block: pg_rd.block,
                       read_ok: 1'b0, write_ok: 1'b0, last: 1'b0};
        if ((pg_rd.flags & M_REF) != '0) begin
          // second chance: back to the tail with enables cleared
          pg_wr_data.flags = pg_rd.flags & ~(M_RE | M_WE | M_REF);
          rg_cmd.push      = 1'b1;
          rg_push          = e_q;
          state_next       = ST_SW_RING;
        end else begin
          pg_wr_data.flags = pg_rd.flags & ~(M_DIRTY | M_RES | M_RE | M_WE);
          pg_wr_data.frame = FW'(FRAMES);
          if ((pg_rd.flags & M_DIRTY) != '0) begin
            emit_val.kind = K_DWRITE;
            state_next    = ST_VICT;
          end else begin
            emit_val.frame = FW'(FRAMES);
            state_next     = ST_LOAD;
          end
        end
      end

      ST_VICT: begin
        emit       = 1'b1;
        emit_val   = '{kind: K_UPDATE, status: 1'b0, owner: e_q[IW-1:VW],
                       page: e_q[VW-1:0], frame: FW'(FRAMES), block: vblk_q,
                       read_ok: 1'b0, write_ok: 1'b0, last: 1'b0};
        state_next = ST_LOAD;
      end

      ST_LOAD: begin
        emit       = 1'b1;
        emit_val   = '{kind: ((ent_q.flags & M_WRITTEN) != '0) ? K_DREAD : K_ZERO,
                       status: 1'b0, owner: proc_q, page: vpage_q, frame: frame_q,
                       block: ent_q.block, read_ok: 1'b0, write_ok: 1'b0,
                       last: 1'b0};
        state_next = ST_LOAD_WR;
      end

      ST_LOAD_WR: begin
        nf = ent_q.flags | M_RE | M_REF | M_RES;
        if (wr_q) begin
          nf = nf | M_WE | M_DIRTY | M_WRITTEN;
        end
        pg_cmd.wr   = 1'b1;
        pg_wr_data  = '{block: ent_q.block, frame: frame_q, flags: nf};
        rg_cmd.push = 1'b1;
        rg_push     = idx;
        emit        = 1'b1;
        emit_val    = '{kind: K_UPDATE, status: 1'b0, owner: proc_q, page: vpage_q,
                        frame: frame_q, block: ent_q.block, read_ok: |(nf & M_RE),
                        write_ok: |(nf & M_WE), last: 1'b1};
        state_next  = ST_IDLE;
      end

      ST_EXT: begin
        fb_cmd.pop     = 1'b1;
        pg_cmd.wr      = 1'b1;
        pg_wr_addr     = {proc_q, totals[proc_q][VW-1:0]};
        pg_wr_data     = '{block: fb_rd, frame: FW'(FRAMES), flags: '0};
        emit           = 1'b1;
        emit_val.page  = totals[proc_q][VW-1:0];
        emit_val.block = fb_rd;
        emit_val.last  = 1'b1;
        state_next     = ST_IDLE;
      end

      ST_DS_RING: begin
        state_next = (walk == walk_n) ? ST_DB_RD : ST_DS_EVAL;
      end

      ST_DS_EVAL: begin
        rg_cmd.pop = 1'b1;
        pg_rd_addr = rg_rd;
        if (rg_rd[IW-1:VW] != proc_q) begin
          rg_cmd.push = 1'b1;
          rg_push     = rg_rd;
          state_next  = ST_DS_RING;
        end else begin
          state_next = ST_DS_FREE;
        end
      end

      ST_DS_FREE: begin
        ff_cmd.push = 1'b1;
        state_next  = ST_DS_RING;
      end

      ST_DB_RD: begin
        pg_rd_addr = {proc_q, bi[VW-1:0]};
        state_next = (bi == totals[proc_q]) ? ST_DS_DONE : ST_DB_PUSH;
      end

      ST_DB_PUSH: begin
        fb_cmd.push = 1'b1;
        state_next  = ST_DB_RD;
      end

      ST_DS_DONE: begin
        pg_cmd.clr    = 1'b1;
        emit          = 1'b1;
        emit_val.last = 1'b1;
        state_next    = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers of the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROCS; i++) begin
        totals[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_EXT:     totals[proc_q] <= totals[proc_q] + TW'(1);
        ST_DS_DONE: totals[proc_q] <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        proc_q  <= proc;
        vpage_q <= vpage;
        wr_q    <= write;
        walk    <= '0;
        walk_n  <= rg_count;
        bi      <= '0;
      end
      ST_FLT_PG: begin
        ent_q   <= pg_rd;
        frame_q <= FW'(ff_rd);
      end
      ST_SW_PAGE: e_q <= rg_rd;
      ST_SW_EVAL: begin
        frame_q <= pg_rd.frame;
        vblk_q  <= pg_rd.block;
      end
      ST_DS_EVAL: walk <= walk + FCW'(1);
      ST_DB_PUSH: bi <= bi + TW'(1);
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    res <= emit_val;
  end

  assign kind     = res.kind;
  assign status   = res.status;
  assign owner    = res.owner;
  assign page     = res.page;
  assign frame    = res.frame;
  assign block    = res.block;
  assign read_ok  = res.read_ok;
  assign write_ok = res.write_ok;
  assign last     = res.last;

  // the final beat of an item comes once the controller is back at rest
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("last beat while busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("inner beat after item end");

  a_ring_cap: assert property (@(posedge clk) disable iff (rst)
    rg_count <= FCW'(FRAMES)) else $error("ring over capacity");

  a_sweep_ring: assert property (@(posedge clk) disable iff (rst)
    state == ST_SW_EVAL |-> rg_count != '0) else $error("sweep on empty ring");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start)) else $error("busy without start");

endmodule

`default_nettype wire
